### rtl/pgmp5_pkg.sv
// Shared types, constants and helpers for the multipage P5 stream parser.
// No dependencies.
package pgmp5_pkg;

  localparam int DimW   = 27;
  localparam int AccW   = 30;
  localparam int ProdW  = 54;
  localparam int MulSteps = 27;
  localparam int DivSteps = 16;

  localparam logic [DimW-1:0] RasterLimit   = 27'd67108864;
  localparam logic [6:0]      MaxExtraPages = 7'd64;
  localparam logic [AccW-1:0] NumberMax     = 30'd100000000;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_NOT_P5    = 3'd2;
  localparam logic [2:0] ST_MALFORMED = 3'd3;
  localparam logic [2:0] ST_GEOMETRY  = 3'd4;
  localparam logic [2:0] ST_NO_TERM   = 3'd5;
  localparam logic [2:0] ST_TOO_LARGE = 3'd6;
  localparam logic [2:0] ST_TRUNCATED = 3'd7;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_PAGES  = 1'b1;

  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_5    = 8'h35;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_0    = 8'h30;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      pixel;
    logic [6:0]      page_number;
    logic [DimW-1:0] page_width;
    logic [DimW-1:0] page_height;
    logic [2:0]      status;
    logic [6:0]      extra_pages;
    logic            last_result;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic commit;
    logic status;
  } cmd_t;

  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic mul_last;
    logic div_last;
    logic eof;
    logic out_free;
  } stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

### rtl/pgm_p5_multipage_stream_parser.sv
// Multipage P5 stream parser: 1 byte per beat in, up to 2 result beats out.
// A byte that closes a header runs a 27-step size multiply, a raster byte a
// 16-step scaling divide, and the final byte of a file adds a status beat;
// output stalls can hold any of these.
// One byte is worked on at a time; a result waits in the output register.
// Synchronous reset returns to expecting 'P' with default budget and limit.
module pgm_p5_multipage_stream_parser import pgmp5_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_t            out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [DimW-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  pgmp5_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pgmp5_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/pgmp5_dp.sv
// Datapath: parse state, shift-add size multiplier, pixel scaling divider,
// configuration registers and output register. Uses pgmp5_pkg.
module pgmp5_dp import pgmp5_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            cmd,
  output stat_t           stat,
  input  in_t             in_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [DimW-1:0] cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_t            out_data
);

  typedef enum logic [2:0] {
    M_EXPECT_P, M_EXPECT_5, M_SKIP, M_DIGITS, M_RASTER, M_BETWEEN, M_STOP, M_ERROR
  } mode_t;

  logic [DimW-1:0] budget_reg;
  logic [6:0]      pages_reg;

  logic [7:0] byte_q;
  logic       eof_q;

  mode_t           mode, mode_next;
  logic            in_comment, ic_next;
  logic [1:0]      nidx, nidx_next;
  logic [AccW-1:0] acc, acc_next;
  logic [AccW-1:0] wv, wv_next;
  logic [AccW-1:0] hv, hv_next;
  logic [7:0]      maxv, maxv_next;
  logic [DimW-1:0] pleft, pleft_next;
  logic [DimW-1:0] bused, bused_next;
  logic [6:0]      page, page_next;
  logic [3:0]      fbc, fbc_next;
  logic [2:0]      err, err_next;

  logic [ProdW-1:0] prod, mcand;
  logic [DimW-1:0]  mplier;
  logic [4:0]       mcnt;

  logic [15:0] dvd, quot;
  logic [7:0]  rem;
  logic [3:0]  dcnt;
  logic [7:0]  divisor;
  logic [8:0]  trial;

  logic [DimW-1:0] budget_now;
  logic [6:0]      plimit;
  logic            geom_bad, too_big;
  logic [ProdW:0]  need_sum;

  logic            res_valid;
  out_t            res, st_res;
  logic            do_skip, ic_eff, fail;
  logic [2:0]      fail_code;

  assign budget_now = (budget_reg < RasterLimit) ? budget_reg : RasterLimit;
  assign plimit     = (pages_reg < MaxExtraPages) ? pages_reg : MaxExtraPages;
  assign geom_bad   = (wv == '0) || (hv == '0) || (acc == '0) || (acc > AccW'(255));
  assign need_sum   = (ProdW+1)'(bused) + {1'b0, prod};
  assign too_big    = (wv > AccW'(budget_now)) || (hv > AccW'(budget_now))
                      || (need_sum > (ProdW+1)'(budget_now));
  assign divisor    = (maxv != '0) ? maxv : 8'd255;
  assign trial      = {rem, dvd[15]};

  assign stat.need_mul = (mode == M_DIGITS) && !is_digit(byte_q) && (nidx == 2'd2);
  assign stat.need_div = (mode == M_RASTER);
  assign stat.mul_last = (mcnt == 5'(MulSteps-1));
  assign stat.div_last = (dcnt == 4'(DivSteps-1));
  assign stat.eof      = eof_q;
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    mode_next  = mode;
    ic_next    = in_comment;
    nidx_next  = nidx;
    acc_next   = acc;
    wv_next    = wv;
    hv_next    = hv;
    maxv_next  = maxv;
    pleft_next = pleft;
    bused_next = bused;
    page_next  = page;
    err_next   = err;
    fbc_next   = (fbc < 4'd8) ? fbc + 4'd1 : fbc;
    res_valid  = 1'b0;
    res        = '0;
    do_skip    = 1'b0;
    ic_eff     = in_comment;
    fail       = 1'b0;
    fail_code  = ST_OK;
    case (mode)
      M_EXPECT_P: begin
        if (byte_q == CHAR_P) begin
          mode_next = M_EXPECT_5;
        end else begin
          fail = 1'b1;
          fail_code = ST_NOT_P5;
        end
      end
      M_EXPECT_5: begin
        if (byte_q == CHAR_5) begin
          mode_next = M_SKIP;
          ic_next   = 1'b0;
          nidx_next = '0;
          acc_next  = '0;
        end else begin
          fail = 1'b1;
          fail_code = ST_NOT_P5;
        end
      end
      M_SKIP: begin
        do_skip = 1'b1;
      end
      M_DIGITS: begin
        if (is_digit(byte_q)) begin
          if (acc > NumberMax) begin
            fail = 1'b1;
            fail_code = ST_MALFORMED;
          end else begin
            acc_next = (acc << 3) + (acc << 1) + AccW'(byte_q - CHAR_0);
          end
        end else if (nidx != 2'd2) begin
          if (nidx == 2'd0) wv_next = acc;
          else hv_next = acc;
          nidx_next = nidx + 2'd1;
          mode_next = M_SKIP;
          ic_eff    = 1'b0;
          do_skip   = 1'b1;
        end else if (geom_bad) begin
          fail = 1'b1;
          fail_code = ST_GEOMETRY;
        end else if (!is_ws(byte_q)) begin
          fail = 1'b1;
          fail_code = ST_NO_TERM;
        end else if (too_big) begin
          fail = 1'b1;
          fail_code = ST_TOO_LARGE;
        end else begin
          if (bused != '0) page_next = page + 7'd1;
          maxv_next  = acc[7:0];
          pleft_next = prod[DimW-1:0];
          bused_next = bused + prod[DimW-1:0];
          mode_next  = M_RASTER;
          res_valid  = 1'b1;
          res.kind        = KIND_START;
          res.page_number = page_next;
          res.page_width  = wv[DimW-1:0];
          res.page_height = hv[DimW-1:0];
        end
      end
      M_RASTER: begin
        res_valid       = 1'b1;
        res.kind        = KIND_PIXEL;
        res.pixel       = quot[7:0];
        res.page_number = page;
        if (pleft != '0) pleft_next = pleft - DimW'(1);
        if (pleft_next == '0) mode_next = (page >= plimit) ? M_STOP : M_BETWEEN;
      end
      M_BETWEEN: begin
        if (byte_q == CHAR_P) mode_next = M_EXPECT_5;
        else if (!is_ws(byte_q)) mode_next = M_STOP;
      end
      default: begin
      end
    endcase
    res.last_result = !eof_q;
    if (do_skip) begin
      ic_next = ic_eff;
      if (ic_eff) begin
        if (byte_q == CHAR_LF) ic_next = 1'b0;
      end else if (is_ws(byte_q)) begin
      end else if (byte_q == CHAR_HASH) begin
        ic_next = 1'b1;
      end else if (is_digit(byte_q)) begin
        acc_next  = AccW'(byte_q - CHAR_0);
        mode_next = M_DIGITS;
      end else begin
        fail = 1'b1;
        fail_code = ST_MALFORMED;
      end
    end
    if (fail) begin
      if (bused == '0) begin
        mode_next = M_ERROR;
        err_next  = fail_code;
      end else begin
        mode_next = M_STOP;
      end
    end
  end

  always_comb begin
    st_res = '0;
    st_res.kind = KIND_STATUS;
    st_res.last_result = 1'b1;
    if (fbc < 4'd8) begin
      st_res.status = ST_SHORT;
    end else if (mode == M_ERROR) begin
      st_res.status = err;
    end else if (bused == '0) begin
      if (mode == M_EXPECT_P || mode == M_EXPECT_5) st_res.status = ST_NOT_P5;
      else if (mode == M_DIGITS && nidx == 2'd2)
        st_res.status = geom_bad ? ST_GEOMETRY : ST_NO_TERM;
      else st_res.status = ST_MALFORMED;
    end else if (mode == M_RASTER && pleft != '0 && page == '0) begin
      st_res.status = ST_TRUNCATED;
    end else begin
      st_res.extra_pages = page;
      if (mode == M_RASTER && pleft != '0 && page != '0) st_res.extra_pages = page - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget_reg <= RasterLimit;
      pages_reg  <= MaxExtraPages;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BUDGET) budget_reg <= cfg_data;
      else pages_reg <= cfg_data[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= in_data.byte_in;
      eof_q  <= in_data.end_of_file;
    end
    if (cmd.mul_start) begin
      prod   <= '0;
      mcand  <= ProdW'(hv[DimW-1:0]);
      mplier <= wv[DimW-1:0];
      mcnt   <= '0;
    end else if (cmd.mul_step) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      mcnt   <= mcnt + 5'd1;
    end
    if (cmd.div_start) begin
      dvd  <= {byte_q, 8'd0} - {8'd0, byte_q};
      rem  <= '0;
      quot <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, divisor}) begin
        rem  <= 8'(trial - {1'b0, divisor});
        quot <= {quot[14:0], 1'b1};
      end else begin
        rem  <= trial[7:0];
        quot <= {quot[14:0], 1'b0};
      end
      dvd  <= dvd << 1;
      dcnt <= dcnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.status) begin
      mode       <= M_EXPECT_P;
      in_comment <= 1'b0;
      nidx       <= '0;
      acc        <= '0;
      wv         <= '0;
      hv         <= '0;
      maxv       <= '0;
      pleft      <= '0;
      bused      <= '0;
      page       <= '0;
      fbc        <= '0;
      err        <= '0;
    end else if (cmd.commit) begin
      mode       <= mode_next;
      in_comment <= ic_next;
      nidx       <= nidx_next;
      acc        <= acc_next;
      wv         <= wv_next;
      hv         <= hv_next;
      maxv       <= maxv_next;
      pleft      <= pleft_next;
      bused      <= bused_next;
      page       <= page_next;
      fbc        <= fbc_next;
      err        <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.status) begin
      out_valid <= 1'b1;
    end else if (cmd.commit && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.status) begin
      out_data <= st_res;
    end else if (cmd.commit && res_valid) begin
      out_data <= res;
    end
  end

endmodule

### rtl/pgmp5_ctrl.sv
// Controller: sequences one byte through decode, multiply or divide, commit
// and result delivery. Uses pgmp5_pkg.
module pgmp5_ctrl import pgmp5_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MUL, S_DIV, S_COMMIT, S_WAIT_RES, S_WAIT_STAT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid && in_ready;
        if (cmd.load) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.need_mul) begin
          cmd.mul_start = 1'b1;
          state_next = S_MUL;
        end else if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) state_next = S_COMMIT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_WAIT_RES;
        end
      end
      S_WAIT_RES: begin
        if (!stat.eof) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.status = 1'b1;
          state_next = S_WAIT_STAT;
        end
      end
      S_WAIT_STAT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

### rtl/pgmp5_chk.sv
// Port-level checker for the P5 stream parser, bound to the top level.
// Uses pgmp5_pkg.
module pgmp5_chk import pgmp5_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input out_t            out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second byte taken while one is in work");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_STATUS |-> out_data.last_result)
    else $error("status beat not marked last");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind pgm_p5_multipage_stream_parser pgmp5_chk u_chk (.*);
